// File: src/plrm_pkg.sv
// Package for the peer liveness and RTT monitor.
// Holds the beat payload types, the controller state type and fixed constants.
// No dependencies; the top level, the cell and the testbench use it.
package plrm_pkg;

    // Event codes carried in the mode field.
    localparam logic [2:0] MODE_SEND_PING = 3'd0;
    localparam logic [2:0] MODE_PONG      = 3'd1;
    localparam logic [2:0] MODE_IN_PING   = 3'd2;
    localparam logic [2:0] MODE_OTHER     = 3'd3;
    localparam logic [2:0] MODE_CHECK     = 3'd4;

    // Incoming ping roles.
    localparam logic KIND_SUCCESSOR = 1'b0;

    // Sequence number that is never issued and marks an unmatched pong.
    localparam logic [7:0] SEQ_SKIP = 8'hff;

    // Reset value of the timeout register.
    localparam logic [30:0] TIMEOUT_RESET = 31'd5000;

    // One input beat.
    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] time_ms;
        logic [7:0]  pong_seqno;
        logic [31:0] pong_time_ms;
        logic        ping_kind;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic [7:0]  issued_seqno;
        logic        pong_matched;
        logic [31:0] rtt_estimate_ms;
        logic        lost_pongs;
        logic        lost_successor_pings;
        logic        lost_long_pings;
    } result_t;

    // Configuration beat: the timeout in milliseconds.
    typedef logic [30:0] cfg_t;

    // One entry of the ping cache.
    typedef struct packed {
        logic [7:0]  seqno;
        logic [31:0] time_ms;
    } ping_entry_t;

    // Per-cell control: take the external value, or take the right neighbor.
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PUSH,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

endpackage

// File: src/plrm_stream_if.sv
// Valid/ready channel interface used for input, result and configuration beats.
// The payload type is a parameter; the types come from plrm_pkg.
interface plrm_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: src/peer_liveness_rtt_monitor_top.sv
// Top level of the peer liveness and RTT monitor.
// Uses plrm_pkg, plrm_stream_if, plrm_cell (cache and window rows) and plrm_divider.
//
//  port    direction  payload     beat
//  item    sink       item_t      one event (ping sent, pong, incoming ping, other, check)
//  result  source     result_t    one result per accepted item
//  cfg     sink       cfg_t       liveness timeout in ms, always ready
//
// An item is accepted in idle; a pong with a valid sequence number scans the cache
// row, one cached ping per cycle, when the cache is not empty; a match is then pushed
// into the window; unless the window is empty, the divider is started and the bit-serial
// divider works through SW = 32 + clog2(RTT_WINDOW_DEPTH+1) dividend bits; last, the
// result register is loaded. The divider sets most of the time an item takes.
// item.ready is high in idle only; a result waiting in the output register does
// not stop the next item from being accepted, but that item then waits in its finish
// state until the register is free. Reset is asynchronous, active low.
module peer_liveness_rtt_monitor_top #(
    parameter int PING_CACHE_DEPTH = 10,
    parameter int RTT_WINDOW_DEPTH = 20
) (
    input  logic clk,
    input  logic rst_n,
    plrm_stream_if.sink   item,
    plrm_stream_if.source result,
    plrm_stream_if.sink   cfg
);

    localparam int PCW = $clog2(PING_CACHE_DEPTH + 1);
    localparam int RCW = $clog2(RTT_WINDOW_DEPTH + 1);
    localparam int SW  = 32 + RCW;
    localparam int PEW = $bits(plrm_pkg::ping_entry_t);

    plrm_pkg::state_t state_reg, state_next;

    logic [30:0]      timeout_reg, timeout_next;
    logic [7:0]       next_seq_reg, next_seq_next;
    logic [PCW-1:0]   ping_cnt_reg, ping_cnt_next;
    logic [PCW-1:0]   scan_cnt_reg, scan_cnt_next;
    logic [RCW-1:0]   rtt_cnt_reg, rtt_cnt_next;
    logic [SW-1:0]    sum_reg, sum_next;
    logic [31:0]      last_msg_reg, last_msg_next;
    logic [31:0]      last_succ_reg, last_succ_next;
    logic [31:0]      last_long_reg, last_long_next;
    logic [31:0]      now_reg, now_next;
    logic [7:0]       pseq_reg, pseq_next;
    logic [31:0]      ptime_reg, ptime_next;
    logic [7:0]       issued_reg, issued_next;
    logic             matched_reg, matched_next;
    logic [31:0]      rtt_reg, rtt_next;
    logic [31:0]      est_reg, est_next;
    logic             out_valid_reg, out_valid_next;
    plrm_pkg::result_t out_data_reg, out_data_next;

    plrm_pkg::cell_ctl_t   ping_ctl [PING_CACHE_DEPTH];
    plrm_pkg::cell_ctl_t   win_ctl [RTT_WINDOW_DEPTH];
    logic [PEW-1:0]        ping_q [PING_CACHE_DEPTH];
    logic [31:0]           win_q [RTT_WINDOW_DEPTH];
    plrm_pkg::ping_entry_t ping_ext;
    plrm_pkg::ping_entry_t head;
    logic [31:0]           win_ext;

    logic          div_start;
    logic          div_done;
    logic [31:0]   div_quot;
    logic          hit;
    logic [7:0]    seq_inc;
    logic [31:0]   d_msg, d_succ, d_long;

    // Ping cache row: entry 0 is the oldest.
    for (genvar i = 0; i < PING_CACHE_DEPTH; i++)
    begin : g_ping
        logic [PEW-1:0] nb;
        if (i == PING_CACHE_DEPTH - 1)
        begin : g_last
            assign nb = ping_q[i];
        end
        else
        begin : g_mid
            assign nb = ping_q[i+1];
        end
        plrm_cell #(.W(PEW)) u_cell (
            .clk (clk),
            .ctl (ping_ctl[i]),
            .ext (ping_ext),
            .nb  (nb),
            .q   (ping_q[i])
        );
    end

    // RTT window row: sample 0 is the oldest.
    for (genvar i = 0; i < RTT_WINDOW_DEPTH; i++)
    begin : g_win
        logic [31:0] nb;
        if (i == RTT_WINDOW_DEPTH - 1)
        begin : g_last
            assign nb = win_q[i];
        end
        else
        begin : g_mid
            assign nb = win_q[i+1];
        end
        plrm_cell #(.W(32)) u_cell (
            .clk (clk),
            .ctl (win_ctl[i]),
            .ext (win_ext),
            .nb  (nb),
            .q   (win_q[i])
        );
    end

    plrm_divider #(.SW(SW), .CW(RCW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (rtt_cnt_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign head = plrm_pkg::ping_entry_t'(ping_q[0]);
    assign hit  = !matched_reg && (head.seqno == pseq_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            plrm_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    if (item.data.mode == plrm_pkg::MODE_PONG &&
                        item.data.pong_seqno != plrm_pkg::SEQ_SKIP &&
                        ping_cnt_reg != '0)
                    begin
                        state_next = plrm_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = plrm_pkg::ST_DIV_START;
                    end
                end
            end
            plrm_pkg::ST_SCAN:
            begin
                if (scan_cnt_reg == PCW'(1))
                begin
                    state_next = (matched_reg || hit) ? plrm_pkg::ST_PUSH
                                                      : plrm_pkg::ST_DIV_START;
                end
            end
            plrm_pkg::ST_PUSH:
            begin
                state_next = plrm_pkg::ST_DIV_START;
            end
            plrm_pkg::ST_DIV_START:
            begin
                state_next = (rtt_cnt_reg == '0) ? plrm_pkg::ST_FINISH
                                                 : plrm_pkg::ST_DIV_WAIT;
            end
            plrm_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = plrm_pkg::ST_FINISH;
                end
            end
            plrm_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = plrm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plrm_pkg::ST_IDLE;
            end
        endcase
    end

    // Timeout distances, read as signed wrap-around differences.
    assign d_msg  = now_reg - last_msg_reg;
    assign d_succ = now_reg - last_succ_reg;
    assign d_long = now_reg - last_long_reg;

    // Sequence number after the one being issued, stepping over the skip code.
    always_comb
    begin
        seq_inc = next_seq_reg + 8'd1;
        if (seq_inc == plrm_pkg::SEQ_SKIP)
        begin
            seq_inc = seq_inc + 8'd1;
        end
    end

    // Datapath and cell control.
    always_comb
    begin
        timeout_next   = timeout_reg;
        next_seq_next  = next_seq_reg;
        ping_cnt_next  = ping_cnt_reg;
        scan_cnt_next  = scan_cnt_reg;
        rtt_cnt_next   = rtt_cnt_reg;
        sum_next       = sum_reg;
        last_msg_next  = last_msg_reg;
        last_succ_next = last_succ_reg;
        last_long_next = last_long_reg;
        now_next       = now_reg;
        pseq_next      = pseq_reg;
        ptime_next     = ptime_reg;
        issued_next    = issued_reg;
        matched_next   = matched_reg;
        rtt_next       = rtt_reg;
        est_next       = est_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ping_ext       = '{seqno: next_seq_reg, time_ms: item.data.time_ms};
        win_ext        = rtt_reg;
        div_start      = 1'b0;
        for (int i = 0; i < PING_CACHE_DEPTH; i++)
        begin
            ping_ctl[i] = '0;
        end
        for (int i = 0; i < RTT_WINDOW_DEPTH; i++)
        begin
            win_ctl[i] = '0;
        end

        // Configuration writes are taken at any time.
        if (cfg.valid)
        begin
            timeout_next = cfg.data;
        end

        // The result register empties when its beat is taken.
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            plrm_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    now_next     = item.data.time_ms;
                    pseq_next    = item.data.pong_seqno;
                    ptime_next   = item.data.pong_time_ms;
                    issued_next  = '0;
                    matched_next = 1'b0;
                    scan_cnt_next = ping_cnt_reg;
                    case (item.data.mode)
                        plrm_pkg::MODE_SEND_PING:
                        begin
                            issued_next   = next_seq_reg;
                            next_seq_next = seq_inc;
                            // A full cache drops its oldest entry.
                            if (ping_cnt_reg == PCW'(PING_CACHE_DEPTH))
                            begin
                                for (int i = 0; i < PING_CACHE_DEPTH; i++)
                                begin
                                    ping_ctl[i].shift = 1'b1;
                                    ping_ctl[i].load  = (i == PING_CACHE_DEPTH - 1);
                                end
                            end
                            else
                            begin
                                for (int i = 0; i < PING_CACHE_DEPTH; i++)
                                begin
                                    ping_ctl[i].load = (PCW'(i) == ping_cnt_reg);
                                end
                                ping_cnt_next = ping_cnt_reg + PCW'(1);
                            end
                        end
                        plrm_pkg::MODE_PONG:
                        begin
                            last_msg_next = item.data.time_ms;
                        end
                        plrm_pkg::MODE_IN_PING:
                        begin
                            if (item.data.ping_kind == plrm_pkg::KIND_SUCCESSOR)
                            begin
                                last_succ_next = item.data.time_ms;
                            end
                            else
                            begin
                                last_long_next = item.data.time_ms;
                            end
                            last_msg_next = item.data.time_ms;
                        end
                        plrm_pkg::MODE_OTHER:
                        begin
                            last_msg_next = item.data.time_ms;
                        end
                        plrm_pkg::MODE_CHECK:
                        begin
                            last_msg_next = last_msg_reg;
                        end
                        default:
                        begin
                            last_msg_next = last_msg_reg;
                        end
                    endcase
                end
            end
            plrm_pkg::ST_SCAN:
            begin
                // The head leaves the row; it is appended at the tail unless it
                // is the first match, so the row comes back in its old order.
                for (int i = 0; i < PING_CACHE_DEPTH; i++)
                begin
                    ping_ctl[i].shift = 1'b1;
                end
                ping_ext = head;
                if (hit)
                begin
                    matched_next  = 1'b1;
                    rtt_next      = ptime_reg - head.time_ms;
                    ping_cnt_next = ping_cnt_reg - PCW'(1);
                end
                else
                begin
                    for (int i = 0; i < PING_CACHE_DEPTH; i++)
                    begin
                        ping_ctl[i].load = (PCW'(i) == ping_cnt_reg - PCW'(1));
                    end
                end
                scan_cnt_next = scan_cnt_reg - PCW'(1);
            end
            plrm_pkg::ST_PUSH:
            begin
                // A full window drops its oldest sample from the row and the sum.
                if (rtt_cnt_reg == RCW'(RTT_WINDOW_DEPTH))
                begin
                    for (int i = 0; i < RTT_WINDOW_DEPTH; i++)
                    begin
                        win_ctl[i].shift = 1'b1;
                        win_ctl[i].load  = (i == RTT_WINDOW_DEPTH - 1);
                    end
                    sum_next = sum_reg + SW'(rtt_reg) - SW'(win_q[0]);
                end
                else
                begin
                    for (int i = 0; i < RTT_WINDOW_DEPTH; i++)
                    begin
                        win_ctl[i].load = (RCW'(i) == rtt_cnt_reg);
                    end
                    rtt_cnt_next = rtt_cnt_reg + RCW'(1);
                    sum_next     = sum_reg + SW'(rtt_reg);
                end
            end
            plrm_pkg::ST_DIV_START:
            begin
                est_next  = '0;
                div_start = (rtt_cnt_reg != '0);
            end
            plrm_pkg::ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    est_next = div_quot;
                end
            end
            plrm_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.issued_seqno    = issued_reg;
                    out_data_next.pong_matched    = matched_reg;
                    out_data_next.rtt_estimate_ms = est_reg;
                    out_data_next.lost_pongs =
                        !d_msg[31] && (d_msg > {1'b0, timeout_reg});
                    out_data_next.lost_successor_pings =
                        !d_succ[31] && (d_succ > {1'b0, timeout_reg});
                    out_data_next.lost_long_pings =
                        !d_long[31] && (d_long > {1'b0, timeout_reg});
                end
            end
            default:
            begin
                est_next = est_reg;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= plrm_pkg::ST_IDLE;
            timeout_reg   <= plrm_pkg::TIMEOUT_RESET;
            next_seq_reg  <= 8'd1;
            ping_cnt_reg  <= '0;
            scan_cnt_reg  <= '0;
            rtt_cnt_reg   <= '0;
            sum_reg       <= '0;
            last_msg_reg  <= '0;
            last_succ_reg <= '0;
            last_long_reg <= '0;
            matched_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            timeout_reg   <= timeout_next;
            next_seq_reg  <= next_seq_next;
            ping_cnt_reg  <= ping_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            rtt_cnt_reg   <= rtt_cnt_next;
            sum_reg       <= sum_next;
            last_msg_reg  <= last_msg_next;
            last_succ_reg <= last_succ_next;
            last_long_reg <= last_long_next;
            matched_reg   <= matched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        pseq_reg     <= pseq_next;
        ptime_reg    <= ptime_next;
        issued_reg   <= issued_next;
        rtt_reg      <= rtt_next;
        est_reg      <= est_next;
        out_data_reg <= out_data_next;
    end

    assign item.ready   = (state_reg == plrm_pkg::ST_IDLE);
    assign cfg.ready    = 1'b1;
    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // The rows never hold more entries than they have cells.
    a_ping_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        ping_cnt_reg <= PCW'(PING_CACHE_DEPTH))
        else $error("ping cache count beyond depth");

    a_rtt_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        rtt_cnt_reg <= RCW'(RTT_WINDOW_DEPTH))
        else $error("rtt window count beyond depth");

    // While scanning, the entries left to look at are all still in the cache.
    a_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plrm_pkg::ST_SCAN) |-> (scan_cnt_reg != '0 &&
                                              scan_cnt_reg <= ping_cnt_reg))
        else $error("cache scan ran past the cached entries");

    // A window push always follows a match.
    a_push: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == plrm_pkg::ST_PUSH) |-> matched_reg)
        else $error("window push without a matched pong");

endmodule

// File: src/plrm_cell.sv
// One storage cell of a shift row (ping cache or RTT window).
// Holds one entry and takes either a broadcast value or its right neighbor.
// Depends on plrm_pkg for the control struct.
module plrm_cell #(
    parameter int W = 32
) (
    input  logic                 clk,
    input  plrm_pkg::cell_ctl_t  ctl,
    input  logic [W-1:0]         ext,
    input  logic [W-1:0]         nb,
    output logic [W-1:0]         q
);

    logic [W-1:0] data_reg;
    logic [W-1:0] data_next;

    // Load has priority over the shift from the neighbor.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.load)
        begin
            data_next = ext;
        end
        else if (ctl.shift)
        begin
            data_next = nb;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

// File: src/plrm_divider.sv
// Restoring divider, one quotient bit per cycle, for the mean RTT.
// Divides the window sum by the sample count; depends on nothing else.
module plrm_divider #(
    parameter int SW = 37,
    parameter int CW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [SW-1:0] dividend,
    input  logic [CW-1:0] divisor,
    output logic          done,
    output logic [31:0]   quotient
);

    localparam int STW = $clog2(SW + 1);

    logic [SW-1:0]  q_reg, q_next;
    logic [CW-1:0]  rem_reg, rem_next;
    logic [CW-1:0]  dvs_reg, dvs_next;
    logic [STW-1:0] step_reg, step_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [CW:0]    rem_sh;
    logic           ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_sh    = {rem_reg, q_reg[SW-1]};
        ge        = (rem_sh >= {1'b0, dvs_reg});
        q_next    = q_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STW'(SW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next    = {q_reg[SW-2:0], ge};
            rem_next  = ge ? CW'(rem_sh - {1'b0, dvs_reg}) : rem_sh[CW-1:0];
            step_next = step_reg - STW'(1);
            if (step_reg == STW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg[31:0];

endmodule

// File: tb/peer_liveness_rtt_monitor_top_tb.sv
// Self-checking testbench for the peer liveness and RTT monitor top level.
// Depends on plrm_pkg, plrm_stream_if and peer_liveness_rtt_monitor_top.
// Events are predicted in the testbench and compared with every result beat.
`timescale 1ns / 1ps

module peer_liveness_rtt_monitor_top_tb;

    localparam int CACHE_DEPTH  = 10;
    localparam int WINDOW_DEPTH = 20;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 80;
    localparam int EXP_DEPTH    = 64;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    plrm_stream_if #(.T(plrm_pkg::item_t))   item_ch();
    plrm_stream_if #(.T(plrm_pkg::result_t)) result_ch();
    plrm_stream_if #(.T(plrm_pkg::cfg_t))    cfg_ch();

    peer_liveness_rtt_monitor_top #(
        .PING_CACHE_DEPTH(CACHE_DEPTH),
        .RTT_WINDOW_DEPTH(WINDOW_DEPTH)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch.sink),
        .result(result_ch.source),
        .cfg(cfg_ch.sink)
    );

    always #10 clk = ~clk;

    // Monitor model state.
    logic [30:0] timeout_ms;
    logic [7:0]  seq_next;
    logic [7:0]  cache_seq [CACHE_DEPTH];
    logic [31:0] cache_time [CACHE_DEPTH];
    int          cache_fill;
    logic [31:0] win_samples [WINDOW_DEPTH];
    int          rtt_fill;
    logic [36:0] rtt_total;
    logic [31:0] last_msg_time;
    logic [31:0] last_succ_time;
    logic [31:0] last_long_time;

    // Expected results, a ring written by the sender and read by the checker.
    plrm_pkg::result_t exp_ring [EXP_DEPTH];
    int      exp_wr = 0;
    int      exp_rd = 0;
    int      error_count = 0;
    int      items_sent = 0;
    int      results_seen = 0;
    int      idle_cycles = 0;
    int      burst_left = 0;
    bit      gaps_on = 1'b1;
    bit      long_hold = 1'b0;
    bit      stall_enable = 1'b1;

    function automatic logic silence_exceeded(logic [31:0] now, logic [31:0] ref_t);
        logic [31:0] d;
        d = now - ref_t;
        return (!d[31]) && (d > {1'b0, timeout_ms});
    endfunction

    // Applies one event to the model and returns the result it should produce.
    function automatic plrm_pkg::result_t monitor_event(plrm_pkg::item_t it);
        plrm_pkg::result_t r;
        int      i;
        int      j;
        r = '0;
        case (it.mode)
            plrm_pkg::MODE_SEND_PING:
            begin
                r.issued_seqno = seq_next;
                seq_next = seq_next + 8'd1;
                if (seq_next == plrm_pkg::SEQ_SKIP)
                    seq_next = seq_next + 8'd1;
                if (cache_fill >= CACHE_DEPTH)
                begin
                    for (j = 0; j < CACHE_DEPTH - 1; j++)
                    begin
                        cache_seq[j] = cache_seq[j + 1];
                        cache_time[j] = cache_time[j + 1];
                    end
                    cache_fill--;
                end
                cache_seq[cache_fill] = r.issued_seqno;
                cache_time[cache_fill] = it.time_ms;
                cache_fill++;
            end
            plrm_pkg::MODE_PONG:
            begin
                last_msg_time = it.time_ms;
                if (it.pong_seqno != plrm_pkg::SEQ_SKIP)
                begin
                    for (i = 0; i < cache_fill; i++)
                    begin
                        if (cache_seq[i] == it.pong_seqno)
                        begin
                            if (rtt_fill >= WINDOW_DEPTH)
                            begin
                                rtt_total = rtt_total - win_samples[0];
                                for (j = 0; j < WINDOW_DEPTH - 1; j++)
                                    win_samples[j] = win_samples[j + 1];
                                rtt_fill--;
                            end
                            win_samples[rtt_fill] = it.pong_time_ms - cache_time[i];
                            rtt_total = rtt_total + win_samples[rtt_fill];
                            rtt_fill++;
                            for (j = i; j + 1 < cache_fill; j++)
                            begin
                                cache_seq[j] = cache_seq[j + 1];
                                cache_time[j] = cache_time[j + 1];
                            end
                            cache_fill--;
                            r.pong_matched = 1'b1;
                            break;
                        end
                    end
                end
            end
            plrm_pkg::MODE_IN_PING:
            begin
                if (it.ping_kind == plrm_pkg::KIND_SUCCESSOR)
                    last_succ_time = it.time_ms;
                else
                    last_long_time = it.time_ms;
                last_msg_time = it.time_ms;
            end
            plrm_pkg::MODE_OTHER:
                last_msg_time = it.time_ms;
            default:
            begin
            end
        endcase
        if (rtt_fill > 0)
            r.rtt_estimate_ms = 32'(rtt_total / rtt_fill);
        r.lost_pongs = silence_exceeded(it.time_ms, last_msg_time);
        r.lost_successor_pings = silence_exceeded(it.time_ms, last_succ_time);
        r.lost_long_pings = silence_exceeded(it.time_ms, last_long_time);
        return r;
    endfunction

    // Sends one event beat; beats come in bursts with a random gap between bursts.
    task automatic send_event(plrm_pkg::item_t it);
        if (gaps_on && burst_left == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        item_ch.valid <= 1'b1;
        item_ch.data <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        exp_ring[exp_wr % EXP_DEPTH] = monitor_event(it);
        exp_wr++;
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_mode(logic [2:0] m, logic [31:0] t, logic [7:0] s = 8'd0,
                             logic [31:0] pt = 32'd0, logic k = 1'b0);
        plrm_pkg::item_t it;
        it.mode = m;
        it.time_ms = t;
        it.pong_seqno = s;
        it.pong_time_ms = pt;
        it.ping_kind = k;
        send_event(it);
    endtask

    // Waits until every expected result has arrived, then lets the block settle.
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (exp_wr != exp_rd)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_timeout(logic [30:0] value);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        timeout_ms = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Directed: every mode, cache overflow, flags.
    task automatic test_directed();
        int n;
        send_mode(plrm_pkg::MODE_CHECK, 32'd6000);
        send_mode(plrm_pkg::MODE_SEND_PING, 32'd100);
        send_mode(plrm_pkg::MODE_PONG, 32'd150, 8'd1, 32'd140);
        send_mode(plrm_pkg::MODE_PONG, 32'd160, 8'd1, 32'd170);
        send_mode(plrm_pkg::MODE_PONG, 32'd170, plrm_pkg::SEQ_SKIP, 32'hffff_ffff);
        send_mode(plrm_pkg::MODE_IN_PING, 32'd200, 8'd0, 32'd0, 1'b0);
        send_mode(plrm_pkg::MODE_IN_PING, 32'hffff_ffff, 8'hff, 32'hffff_ffff, 1'b1);
        send_mode(plrm_pkg::MODE_OTHER, 32'h8000_0000);
        send_mode(3'd5, 32'h7fff_ffff);
        send_mode(3'd7, 32'd0);
        for (n = 0; n < 12; n++)
            send_mode(plrm_pkg::MODE_SEND_PING, 32'd1000 + n);
        send_mode(plrm_pkg::MODE_PONG, 32'd2000, 8'd2, 32'd5);
        send_mode(plrm_pkg::MODE_PONG, 32'd2000, 8'd13, 32'hffff_fff0);
        send_mode(plrm_pkg::MODE_CHECK, 32'hffff_ffff);
    endtask

    task automatic test_seq_wrap();
        int n;
        for (n = 0; n < 270; n++)
        begin
            send_mode(plrm_pkg::MODE_SEND_PING, $urandom());
            if (n % 3 == 0)
                send_mode(plrm_pkg::MODE_PONG, $urandom(), seq_next - 8'd1, $urandom());
        end
    endtask

    // Random traffic: pings, pongs that mostly match a cached ping, stray pongs and other events.
    task automatic test_random(int count);
        logic [31:0] now;
        int          n;
        int          pick;
        logic [7:0]  s;
        now = $urandom();
        for (n = 0; n < count; n++)
        begin
            now = now + $urandom_range(0, 3000);
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_mode(plrm_pkg::MODE_SEND_PING, now);
            else if (pick < 60)
            begin
                s = (cache_fill > 0) ? cache_seq[$urandom_range(0, cache_fill - 1)]
                                     : 8'($urandom());
                send_mode(plrm_pkg::MODE_PONG, now, s, now + $urandom_range(0, 500));
            end
            else if (pick < 65)
                send_mode(plrm_pkg::MODE_PONG, $urandom(), 8'($urandom()), $urandom());
            else if (pick < 80)
                send_mode(plrm_pkg::MODE_IN_PING, now, 8'($urandom()), $urandom(),
                          1'($urandom()));
            else if (pick < 88)
                send_mode(plrm_pkg::MODE_OTHER, now);
            else
                send_mode(3'($urandom_range(4, 7)), ($urandom_range(0, 9) == 0) ? $urandom()
                          : now, 8'($urandom()), $urandom(), 1'($urandom()));
        end
    endtask

    // Long receiver hold-off while items keep coming, so the input stalls.
    task automatic test_backpressure();
        int n;
        long_hold = 1'b1;
        gaps_on = 1'b0;
        for (n = 0; n < 6; n++)
            send_mode(plrm_pkg::MODE_SEND_PING, 32'd50 * n);
        gaps_on = 1'b1;
        long_hold = 1'b0;
    endtask

    // Receiver stall pattern and the long hold-off, counted in its own process.
    initial
    begin
        int hold;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                result_ch.ready <= 1'b0;
                for (hold = 0; hold < 400; hold++)
                    @(negedge clk);
                result_ch.ready <= 1'b1;
                wait (!long_hold);
            end
            else if (stall_enable)
                result_ch.ready <= ($urandom_range(0, 9) < 6);
            else
                result_ch.ready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        plrm_pkg::result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            results_seen++;
            if (exp_wr == exp_rd)
            begin
                $display("%0t: unexpected result beat %h", $time, result_ch.data);
                error_count++;
            end
            else
            begin
                want = exp_ring[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (want.issued_seqno !== result_ch.data.issued_seqno ||
                    want.pong_matched !== result_ch.data.pong_matched ||
                    want.rtt_estimate_ms !== result_ch.data.rtt_estimate_ms ||
                    want.lost_pongs !== result_ch.data.lost_pongs ||
                    want.lost_successor_pings !== result_ch.data.lost_successor_pings ||
                    want.lost_long_pings !== result_ch.data.lost_long_pings)
                begin
                    $display("%0t: result mismatch expected %h actual %h",
                             $time, want, result_ch.data);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        timeout_ms = plrm_pkg::TIMEOUT_RESET;
        seq_next = 8'd1;
        cache_fill = 0;
        rtt_fill = 0;
        rtt_total = '0;
        last_msg_time = '0;
        last_succ_time = '0;
        last_long_time = '0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_backpressure();
        write_timeout(31'd0);
        test_directed();
        test_random(120);
        write_timeout(31'h7fff_ffff);
        test_random(120);
        write_timeout(31'd1500);
        stall_enable = 1'b0;
        test_random(120);
        stall_enable = 1'b1;
        test_seq_wrap();
        write_timeout(31'($urandom()));
        test_random(150);
        write_timeout(31'd5000);
        test_random(120);
        wait_drained();

        $display("Sent %0d events and checked %0d results over five timeout settings,",
                 items_sent, results_seen);
        $display("covering sequence wrap, cache and window overflow and input stalls.");
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
